// ===== rtl/tkvc_pkg.sv =====
package tkvc_pkg;

    localparam int ENTRIES_DEF     = 16;
    localparam int KEY_BITS_DEF    = 64;
    localparam int VALUE_BYTES_DEF = 8;
    localparam logic [15:0] TTL_RESET = 16'd60;

    typedef enum logic [2:0] {
        KIND_GET   = 3'd0,
        KIND_PUT   = 3'd1,
        KIND_INVAL = 3'd2,
        KIND_TICK  = 3'd3,
        KIND_CLEAR = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/ttl_key_value_cache.sv =====
// Fully associative key/value cache with age expiry. Each transaction on the
// s_axis side carries one operation (get, put, invalidate, tick, statistics
// reset) and yields exactly one result transaction on m_axis. Entries live in
// a synchronous memory with a registered read port; get, put and invalidate
// walk the slots one per cycle, ending early when a live matching key is
// found, while tick, statistics reset and over-long puts skip the walk. A new
// operation is accepted once the previous result has moved to the output
// register. Valid bits are flip-flops cleared by reset; the user must write the
// TTL register over the cfg channel only while the block is idle, which the
// block itself does not enforce.
module ttl_key_value_cache #(
    parameter int ENTRIES     = tkvc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS    = tkvc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BYTES = tkvc_pkg::VALUE_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // key[63:0], put_value[127:64], put_len[135:128], buffer_room[143:136]
    input  logic [143:0] s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit[0], read_value[64:1], read_len[68:65], hit_count[100:69],
    // miss_count[132:101], put_count[164:133], invalidate_count[196:165]
    output logic [199:0] m_axis_tdata
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = 4;
    localparam int EW = KEY_BITS + 64 + LW + 32;

    tkvc_pkg::state_t state_reg, state_next;

    logic [EW-1:0]      mem [ENTRIES];
    logic [EW-1:0]      rd_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;

    logic [2:0]          kind_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [63:0]         pval_reg;
    logic [7:0]          plen_reg, room_reg;
    logic [15:0]         ttl_reg;
    logic [31:0]         now_reg, now_next;
    logic [31:0]         hits_reg, hits_next, miss_reg, miss_next;
    logic [31:0]         puts_reg, puts_next, invs_reg, invs_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rd_live_reg, rd_live_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          found_reg, found_next, free_reg, free_next;
    logic [IW-1:0] found_idx_reg, found_idx_next, free_idx_reg, free_idx_next;
    logic [63:0]   fval_reg, fval_next;
    logic [LW-1:0] flen_reg, flen_next;

    logic          ov_reg, ov_next;
    logic [63:0]   ovval_reg, ovval_next;
    logic [LW-1:0] ovlen_reg, ovlen_next;

    logic          we;
    logic [IW-1:0] waddr;
    logic [EW-1:0] wdata;

    logic [KEY_BITS-1:0] e_key;
    logic [63:0]         e_val;
    logic [LW-1:0]       e_len;
    logic [31:0]         e_stamp;
    logic                e_exp;
    logic [63:0]         bmask;
    logic                accept;

    assign {e_stamp, e_len, e_val, e_key} = rd_reg;
    assign e_exp  = (now_reg - e_stamp) > {16'd0, ttl_reg};
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == tkvc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        bmask = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (b < plen_reg)
            begin
                bmask[8*b +: 8] = 8'hFF;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[rd_idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tkvc_pkg::ST_IDLE;
            valid_reg     <= '0;
            ttl_reg       <= tkvc_pkg::TTL_RESET;
            now_reg       <= '0;
            hits_reg      <= '0;
            miss_reg      <= '0;
            puts_reg      <= '0;
            invs_reg      <= '0;
            cnt_reg       <= '0;
            rd_live_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            found_idx_reg <= '0;
            free_idx_reg  <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            now_reg       <= now_next;
            hits_reg      <= hits_next;
            miss_reg      <= miss_next;
            puts_reg      <= puts_next;
            invs_reg      <= invs_next;
            cnt_reg       <= cnt_next;
            rd_live_reg   <= rd_live_next;
            rd_idx_reg    <= rd_idx_next;
            found_reg     <= found_next;
            free_reg      <= free_next;
            found_idx_reg <= found_idx_next;
            free_idx_reg  <= free_idx_next;
            ov_reg        <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                ttl_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= s_axis_tuser;
            key_reg  <= s_axis_tdata[KEY_BITS-1:0];
            pval_reg <= s_axis_tdata[127:64];
            plen_reg <= s_axis_tdata[135:128];
            room_reg <= s_axis_tdata[143:136];
        end
        fval_reg  <= fval_next;
        flen_reg  <= flen_next;
        ovval_reg <= ovval_next;
        ovlen_reg <= ovlen_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        now_next       = now_reg;
        hits_next      = hits_reg;
        miss_next      = miss_reg;
        puts_next      = puts_reg;
        invs_next      = invs_reg;
        cnt_next       = cnt_reg;
        rd_live_next   = 1'b0;
        rd_idx_next    = rd_idx_reg;
        found_next     = found_reg;
        free_next      = free_reg;
        found_idx_next = found_idx_reg;
        free_idx_next  = free_idx_reg;
        fval_next      = fval_reg;
        flen_next      = flen_reg;
        ov_next        = ov_reg;
        ovval_next     = ovval_reg;
        ovlen_next     = ovlen_reg;
        we             = 1'b0;
        waddr          = found_reg ? found_idx_reg : (free_reg ? free_idx_reg : '0);
        wdata          = {now_reg, plen_reg[LW-1:0], pval_reg & bmask, key_reg};
        case (state_reg)
            tkvc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next    = '0;
                    rd_idx_next = '0;
                    found_next  = 1'b0;
                    free_next   = 1'b0;
                    fval_next   = '0;
                    flen_next   = '0;
                    state_next  = tkvc_pkg::ST_OUT;
                    case (s_axis_tuser)
                        tkvc_pkg::KIND_GET, tkvc_pkg::KIND_INVAL:
                        begin
                            state_next   = tkvc_pkg::ST_SCAN;
                            rd_live_next = 1'b1;
                        end
                        tkvc_pkg::KIND_PUT:
                        begin
                            if (s_axis_tdata[135:128] <= 8'(VALUE_BYTES))
                            begin
                                state_next   = tkvc_pkg::ST_SCAN;
                                rd_live_next = 1'b1;
                            end
                        end
                        tkvc_pkg::KIND_TICK:
                        begin
                            now_next = now_reg + 32'd1;
                        end
                        tkvc_pkg::KIND_CLEAR:
                        begin
                            hits_next = '0;
                            miss_next = '0;
                            puts_next = '0;
                            invs_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            tkvc_pkg::ST_SCAN:
            begin
                if (rd_live_reg && !found_reg)
                begin
                    if (valid_reg[rd_idx_reg] && e_exp)
                    begin
                        valid_next[rd_idx_reg] = 1'b0;
                    end
                    if (!valid_reg[rd_idx_reg] || e_exp)
                    begin
                        if (!free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = rd_idx_reg;
                        end
                    end
                    else if (e_key == key_reg)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = rd_idx_reg;
                        fval_next      = e_val;
                        flen_next      = e_len;
                    end
                end
                if (rd_live_reg && !found_next && (cnt_reg + CW'(1)) < CW'(ENTRIES))
                begin
                    cnt_next     = cnt_reg + CW'(1);
                    rd_idx_next  = cnt_next[IW-1:0];
                    rd_live_next = 1'b1;
                end
                else
                begin
                    state_next = tkvc_pkg::ST_WRITE;
                end
            end
            tkvc_pkg::ST_WRITE:
            begin
                state_next = tkvc_pkg::ST_OUT;
                case (kind_reg)
                    tkvc_pkg::KIND_GET:
                    begin
                        if (found_reg && ({4'd0, flen_reg} <= room_reg))
                        begin
                            hits_next = hits_reg + 32'd1;
                        end
                        else
                        begin
                            found_next = 1'b0;
                            miss_next  = miss_reg + 32'd1;
                        end
                    end
                    tkvc_pkg::KIND_PUT:
                    begin
                        we                = 1'b1;
                        valid_next[waddr] = 1'b1;
                        puts_next         = puts_reg + 32'd1;
                        found_next        = 1'b0;
                    end
                    default:
                    begin
                        if (found_reg)
                        begin
                            valid_next[found_idx_reg] = 1'b0;
                        end
                        invs_next  = invs_reg + 32'd1;
                        found_next = 1'b0;
                    end
                endcase
            end
            tkvc_pkg::ST_OUT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next    = 1'b1;
                    ovval_next = found_reg ? fval_reg : '0;
                    ovlen_next = found_reg ? flen_reg : '0;
                    state_next = tkvc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tkvc_pkg::ST_IDLE;
            end
        endcase
        if (ov_reg && m_axis_tready && !(state_reg == tkvc_pkg::ST_OUT))
        begin
            ov_next = 1'b0;
        end
    end

    logic [31:0] oh_reg, om_reg, op_reg, oi_reg;
    logic        ohit_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == tkvc_pkg::ST_OUT && (!ov_reg || m_axis_tready))
        begin
            ohit_reg <= found_reg;
            oh_reg   <= hits_reg;
            om_reg   <= miss_reg;
            op_reg   <= puts_reg;
            oi_reg   <= invs_reg;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {3'd0, oi_reg, op_reg, om_reg, oh_reg, ovlen_reg, ovval_reg,
                            ohit_reg};

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tkvc_pkg::ST_IDLE) |-> !s_axis_tready)
        else $error("Input accepted while busy.");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("Result changed while stalled.");
    a_write_only_put: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == tkvc_pkg::ST_WRITE && kind_reg == tkvc_pkg::KIND_PUT))
        else $error("Memory write outside put.");
    a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tkvc_pkg::ST_WRITE && kind_reg == tkvc_pkg::KIND_GET)
        |=> ($countones({hits_reg != $past(hits_reg), miss_reg != $past(miss_reg)}) == 1))
        else $error("Get must update exactly one counter.");
`endif

endmodule
